>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. They compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MQSR_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define MQSR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define MQSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MQSR_ASSERT(lbl, cond, msg)
`define MQSR_ASSERT_IMPL(lbl, ante, cons, msg)
`define MQSR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/mqsr_pkg.sv
// ----------------------------------------------------------------------------
// mqsr_pkg
// Types and codes of the mailbox queue with selective receive.
// ----------------------------------------------------------------------------
`default_nettype none
package mqsr_pkg;
	localparam int PROC_COUNT_DEF = 64;
	localparam int POOL_DEPTH_DEF = 64;

	localparam logic [1:0] CMD_SEND  = 2'd0;
	localparam logic [1:0] CMD_CHECK = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NO_MSG = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic [5:0]  box;
		logic [5:0]  sender;
		logic [30:0] id;
		logic [7:0]  op;
	} msg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_OUT
	} state_t;
endpackage
`default_nettype wire

>>> hw/rtl/mqsr_in_if.sv
// ----------------------------------------------------------------------------
// mqsr_in_if
// Command channel: valid/ready handshake with the command fields.
// ----------------------------------------------------------------------------
`default_nettype none
interface mqsr_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [5:0]  mailbox_proc;
	logic [5:0]  sender_proc;
	logic        any_sender;
	logic [30:0] msg_id;
	logic [7:0]  msg_op;

	modport source(output valid, cmd, mailbox_proc, sender_proc, any_sender, msg_id, msg_op,
		input ready);
	modport sink(input valid, cmd, mailbox_proc, sender_proc, any_sender, msg_id, msg_op,
		output ready);
endinterface
`default_nettype wire

>>> hw/rtl/mqsr_out_if.sv
// ----------------------------------------------------------------------------
// mqsr_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
`default_nettype none
interface mqsr_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [5:0]  out_sender;
	logic [30:0] out_id;
	logic [7:0]  out_op;
	logic [1:0]  status;

	modport source(output valid, found, out_sender, out_id, out_op, status, input ready);
	modport sink(input valid, found, out_sender, out_id, out_op, status, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/mqsr_cell.sv
// ----------------------------------------------------------------------------
// mqsr_cell
// One message slot of the age-ordered chain; compares itself to the search key.
// ----------------------------------------------------------------------------
`default_nettype none
module mqsr_cell (
	input  wire logic            clk,
	input  wire logic            load,
	input  wire logic            shift,
	input  wire mqsr_pkg::msg_t  din,
	input  wire mqsr_pkg::msg_t  nxt,
	input  wire logic [5:0]      key_box,
	input  wire logic [5:0]      key_sender,
	input  wire logic            key_any,
	output mqsr_pkg::msg_t       q,
	output logic                 match
);
	mqsr_pkg::msg_t msg_q;

	// A removal moves every younger message one slot toward the head.
	always_ff @(posedge clk) begin
		if (load) begin
			msg_q <= din;
		end else if (shift) begin
			msg_q <= nxt;
		end
	end

	assign q     = msg_q;
	assign match = (msg_q.box == key_box) && (key_any || (msg_q.sender == key_sender));
endmodule
`default_nettype wire

>>> hw/rtl/mailbox_queue_selective_receive.sv
// ----------------------------------------------------------------------------
// mailbox_queue_selective_receive
// Per-process mailboxes over a shared pool, with selective receive.
// ----------------------------------------------------------------------------
// All messages live in one chain of POOL_DEPTH cells kept in arrival order,
// so each mailbox's messages appear oldest first. A send offers its result in
// the cycle after the command transfer, and the block takes a new command in
// the cycle after the result transfer. A check or flush walks the chain one
// cell per cycle from the head: a check stops at its first hit, and a failed
// check or a flush walks on until past the last stored message. A removal
// compacts the chain in the same cycle, and a flush stays on the slot after
// each removal. Stalls on the result side hold the block in its output state.
`default_nettype none
`include "assert_macros.svh"
module mailbox_queue_selective_receive #(
	parameter int PROC_COUNT = mqsr_pkg::PROC_COUNT_DEF,
	parameter int POOL_DEPTH = mqsr_pkg::POOL_DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mqsr_in_if.sink     req,
	mqsr_out_if.source  rsp
);
	localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int CW = $clog2(POOL_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

	mqsr_pkg::state_t state_q, state_d;
	logic [CW-1:0]    pos_q, count_q;
	logic [1:0]       cmd_q;
	logic [5:0]       box_q, snd_q;
	logic             any_q;
	logic             found_q;
	mqsr_pkg::msg_t   res_q;
	logic [1:0]       status_q;

	mqsr_pkg::msg_t   cell_q [POOL_DEPTH];
	logic             cell_match [POOL_DEPTH];
	mqsr_pkg::msg_t   din;

	logic req_fire, in_range, go_scan, scan_end, hit, shift_en, load_en;
	logic [IW-1:0] pos_idx;

	assign req_fire = req.valid && req.ready;
	assign in_range = 32'(req.mailbox_proc) < PROC_COUNT;
	assign go_scan  = in_range &&
		(req.cmd == mqsr_pkg::CMD_CHECK || req.cmd == mqsr_pkg::CMD_FLUSH);
	assign pos_idx  = pos_q[IW-1:0];
	assign scan_end = (pos_q == count_q);
	assign hit      = !scan_end && cell_match[pos_idx];
	assign din      = '{box: req.mailbox_proc, sender: req.sender_proc,
		id: req.msg_id, op: req.msg_op};

	for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
		mqsr_cell u_cell (
			.clk        (clk),
			.load       (load_en && (count_q == CW'(i))),
			.shift      (shift_en && (CW'(i) >= pos_q)),
			.din        (din),
			.nxt        ((i == POOL_DEPTH - 1) ? cell_q[i] : cell_q[(i + 1) % POOL_DEPTH]),
			.key_box    (box_q),
			.key_sender (snd_q),
			.key_any    (any_q || (cmd_q == mqsr_pkg::CMD_FLUSH)),
			.q          (cell_q[i]),
			.match      (cell_match[i])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mqsr_pkg::S_IDLE: begin
				if (req_fire) begin
					state_d = go_scan ? mqsr_pkg::S_SCAN : mqsr_pkg::S_OUT;
				end
			end
			mqsr_pkg::S_SCAN: begin
				if (scan_end || (hit && cmd_q == mqsr_pkg::CMD_CHECK)) begin
					state_d = mqsr_pkg::S_OUT;
				end
			end
			mqsr_pkg::S_OUT: begin
				if (rsp.ready) begin
					state_d = mqsr_pkg::S_IDLE;
				end
			end
			default: state_d = mqsr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == mqsr_pkg::S_IDLE);
		rsp.valid = (state_q == mqsr_pkg::S_OUT);
		shift_en  = (state_q == mqsr_pkg::S_SCAN) && hit;
		load_en   = req_fire && in_range && (req.cmd == mqsr_pkg::CMD_SEND) &&
			(count_q != DEPTH_C);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mqsr_pkg::S_IDLE;
			pos_q   <= '0;
			count_q <= DEPTH_C - DEPTH_C;
		end else begin
			state_q <= state_d;
			if (req_fire) begin
				pos_q <= '0;
			end else if ((state_q == mqsr_pkg::S_SCAN) && !scan_end && !hit) begin
				pos_q <= pos_q + CW'(1);
			end
			if (load_en) begin
				count_q <= count_q + CW'(1);
			end else if (shift_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q    <= req.cmd;
			box_q    <= req.mailbox_proc;
			snd_q    <= req.sender_proc;
			any_q    <= req.any_sender;
			found_q  <= 1'b0;
			res_q    <= '0;
			if (!in_range) begin
				status_q <= mqsr_pkg::ST_NO_MSG;
			end else if (req.cmd == mqsr_pkg::CMD_SEND && count_q == DEPTH_C) begin
				status_q <= mqsr_pkg::ST_FULL;
			end else begin
				status_q <= mqsr_pkg::ST_OK;
			end
		end else if (state_q == mqsr_pkg::S_SCAN) begin
			if (hit && cmd_q == mqsr_pkg::CMD_CHECK) begin
				found_q <= 1'b1;
				res_q   <= cell_q[pos_idx];
			end else if (scan_end && cmd_q == mqsr_pkg::CMD_CHECK) begin
				status_q <= mqsr_pkg::ST_NO_MSG;
			end
		end
	end

	assign rsp.found      = found_q;
	assign rsp.out_sender = res_q.sender;
	assign rsp.out_id     = res_q.id;
	assign rsp.out_op     = res_q.op;
	assign rsp.status     = status_q;

	`MQSR_ASSERT(a_count_max, count_q <= DEPTH_C, "message count above pool depth")
	`MQSR_ASSERT(a_pos_le_count, pos_q <= count_q, "scan position beyond stored messages")
	`MQSR_ASSERT_NEXT(a_shift_dec, shift_en, count_q == $past(count_q) - CW'(1), "removal lost")
	`MQSR_ASSERT_IMPL(a_found_ok, rsp.valid && rsp.found, rsp.status == mqsr_pkg::ST_OK, "found with error status")
	`MQSR_ASSERT_IMPL(a_no_accept_busy, state_q != mqsr_pkg::S_IDLE, !req.ready, "command taken while busy")
endmodule
`default_nettype wire
